// ----- src/gbn_pkg.sv -----
// Package with payload types, codes and constants of the Go-Back-N sender.
`default_nettype none
package gbn_pkg;
	localparam int RingSlots = 16;
	localparam int SlotW = 4;
	localparam int Window = 8;
	localparam int MaxPayload = 1024;

	localparam logic [2:0] KIND_OPEN = 3'd0;
	localparam logic [2:0] KIND_SEND = 3'd1;
	localparam logic [2:0] KIND_RECV = 3'd2;
	localparam logic [2:0] KIND_CLOSE = 3'd3;
	localparam logic [2:0] KIND_TICK = 3'd4;

	localparam logic [2:0] RX_SYNACK = 3'd1;
	localparam logic [2:0] RX_FINACK = 3'd3;
	localparam logic [2:0] RX_DATAACK = 3'd5;

	localparam logic [1:0] TX_SYN = 2'd0;
	localparam logic [1:0] TX_FIN = 2'd1;
	localparam logic [1:0] TX_DATA = 2'd2;

	localparam logic [2:0] ST_NONE = 3'd0;
	localparam logic [2:0] ST_ACCEPTED = 3'd1;
	localparam logic [2:0] ST_REJECTED = 3'd2;
	localparam logic [2:0] ST_CONNECTED = 3'd3;
	localparam logic [2:0] ST_CONN_FAIL = 3'd4;
	localparam logic [2:0] ST_CLOSED = 3'd5;
	localparam logic [2:0] ST_CLOSE_FAIL = 3'd6;

	localparam logic [1:0] CS_CLOSED = 2'd0;
	localparam logic [1:0] CS_SYNSENT = 2'd1;
	localparam logic [1:0] CS_CONNECTED = 2'd2;
	localparam logic [1:0] CS_FINWAIT = 2'd3;

	localparam logic [2:0] REG_LOCAL_PORT = 3'd0;
	localparam logic [2:0] REG_REMOTE_PORT = 3'd1;
	localparam logic [2:0] REG_HS_TIMEOUT = 3'd2;
	localparam logic [2:0] REG_HS_RETRIES = 3'd3;
	localparam logic [2:0] REG_CL_TIMEOUT = 3'd4;
	localparam logic [2:0] REG_CL_RETRIES = 3'd5;
	localparam logic [2:0] REG_RESEND_AGE = 3'd6;

	typedef struct packed {
		logic [2:0] kind;
		logic [10:0] seg_length;
		logic [2:0] rx_type;
		logic [15:0] rx_src_port;
		logic [15:0] rx_dest_port;
		logic [31:0] rx_ack_num;
	} in_word_t;

	typedef struct packed {
		logic has_segment;
		logic [1:0] tx_type;
		logic [31:0] tx_seq;
		logic [10:0] tx_length;
		logic [3:0] tx_slot;
		logic [2:0] status;
		logic last;
	} out_word_t;

	typedef struct packed {
		logic [15:0] local_port;
		logic [15:0] remote_port;
		logic [15:0] hs_timeout;
		logic [7:0] hs_retries;
		logic [15:0] cl_timeout;
		logic [7:0] cl_retries;
		logic [15:0] resend_age;
	} cfg_t;
endpackage
`default_nettype wire

// ----- src/gbn_ram.sv -----
// Generic single-port-write RAM with one registered read port.
`default_nettype none
module gbn_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- src/gbn_cfg.sv -----
// APB register file holding the connection configuration.
`default_nettype none
module gbn_cfg import gbn_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output cfg_t cfg
);
	cfg_t cfg_q;
	logic [2:0] idx;
	assign idx = paddr[4:2];
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{16'd0, 16'd0, 16'd1, 8'd5, 16'd1, 8'd5, 16'd1};
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_LOCAL_PORT: cfg_q.local_port <= pwdata[15:0];
				REG_REMOTE_PORT: cfg_q.remote_port <= pwdata[15:0];
				REG_HS_TIMEOUT: cfg_q.hs_timeout <= pwdata[15:0];
				REG_HS_RETRIES: cfg_q.hs_retries <= pwdata[7:0];
				REG_CL_TIMEOUT: cfg_q.cl_timeout <= pwdata[15:0];
				REG_CL_RETRIES: cfg_q.cl_retries <= pwdata[7:0];
				REG_RESEND_AGE: cfg_q.resend_age <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LOCAL_PORT: prdata = {16'd0, cfg_q.local_port};
			REG_REMOTE_PORT: prdata = {16'd0, cfg_q.remote_port};
			REG_HS_TIMEOUT: prdata = {16'd0, cfg_q.hs_timeout};
			REG_HS_RETRIES: prdata = {24'd0, cfg_q.hs_retries};
			REG_CL_TIMEOUT: prdata = {16'd0, cfg_q.cl_timeout};
			REG_CL_RETRIES: prdata = {24'd0, cfg_q.cl_retries};
			REG_RESEND_AGE: prdata = {16'd0, cfg_q.resend_age};
			default: prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

// ----- src/gbn_front.sv -----
// Front end: takes input words into a two-entry queue for the engine.
`default_nettype none
module gbn_front import gbn_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire in_word_t in_word,
	output logic cmd_valid,
	input wire logic cmd_take,
	output in_word_t cmd_word
);
	in_word_t q_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd_word = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= in_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (cmd_take) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_take};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cmd_take |-> cmd_valid)
		else $error("engine took a word from an empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !cmd_take) |=> cnt_q == 2'd2)
		else $error("full queue lost a word");
endmodule
`default_nettype wire

// ----- src/gbn_engine.sv -----
// Back end: connection state machine, ring bookkeeping and segment emission.
`default_nettype none
module gbn_engine import gbn_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire logic cmd_valid,
	output logic cmd_take,
	input wire in_word_t cmd_word,
	output logic out_valid,
	input wire logic out_stall,
	output out_word_t out_word
);
	localparam logic [2:0] P_IDLE = 3'd0;
	localparam logic [2:0] P_FILL = 3'd1;
	localparam logic [2:0] P_POP = 3'd2;
	localparam logic [2:0] P_AGE = 3'd3;
	localparam logic [2:0] P_RESEND = 3'd4;
	localparam logic [2:0] P_EMIT = 3'd5;

	logic [2:0] ph_q;
	logic [1:0] cs_q;
	logic [31:0] nseq_q, tick_q, ack_q;
	logic [7:0] rcnt_q;
	logic [15:0] rtim_q;
	logic [SlotW-1:0] head_q, unsent_q, ptr_q;
	logic [SlotW:0] fill_q;
	logic [SlotW:0] unack_q;
	logic [3:0] nres_q;
	logic [SlotW:0] k_q;
	logic send_q;
	logic rd_ok_q;
	out_word_t pend_q;
	logic pend_v_q;
	out_word_t ob_q;
	logic ob_v_q;

	// Ring stores: sequence, length and sent tick, one RAM each.
	logic [SlotW-1:0] raddr;
	logic [31:0] seq_rd, tk_rd;
	logic [10:0] len_rd;
	logic we_sl, we_tk;
	logic [SlotW-1:0] wa_sl, wa_tk;
	logic [31:0] wd_seq, wd_tk;
	logic [10:0] wd_len;

	gbn_ram #(.Width(32), .Depth(RingSlots)) u_seq (.clk, .we(we_sl), .waddr(wa_sl),
		.wdata(wd_seq), .raddr, .rdata(seq_rd));
	gbn_ram #(.Width(11), .Depth(RingSlots)) u_len (.clk, .we(we_sl), .waddr(wa_sl),
		.wdata(wd_len), .raddr, .rdata(len_rd));
	gbn_ram #(.Width(32), .Depth(RingSlots)) u_tk (.clk, .we(we_tk), .waddr(wa_tk),
		.wdata(wd_tk), .raddr, .rdata(tk_rd));

	logic ob_free;
	assign ob_free = !ob_v_q || !out_stall;
	assign out_valid = ob_v_q;
	assign out_word = ob_q;

	// Results go through a one-word hold (pend) so that last can be set on the final one.
	logic ob_load;
	out_word_t ob_next;

	logic [10:0] sat_len;
	assign sat_len = (cmd_word.seg_length > 11'(MaxPayload)) ? 11'(MaxPayload)
		: cmd_word.seg_length;
	logic ports_ok;
	assign ports_ok = cmd_word.rx_dest_port == cfg.local_port
		&& cmd_word.rx_src_port == cfg.remote_port;
	logic [15:0] ntim;
	assign ntim = rtim_q + 16'd1;
	logic syn;
	assign syn = (cs_q == CS_SYNSENT);
	logic [15:0] lim;
	logic [7:0] tries;
	assign lim = syn ? cfg.hs_timeout : cfg.cl_timeout;
	assign tries = syn ? cfg.hs_retries : cfg.cl_retries;
	logic retry_due;
	assign retry_due = (cs_q == CS_SYNSENT || cs_q == CS_FINWAIT) && ntim >= lim;

	logic can_fill;
	assign can_fill = unack_q < (SlotW+1)'(Window) && unack_q < fill_q && nres_q < 4'd8;

	logic resend_go;
	assign resend_go = k_q != unack_q && nres_q != 4'd8 && rd_ok_q && ob_free;

	assign raddr = ptr_q;

	function automatic out_word_t mk(input logic h, input logic [1:0] t, input logic [31:0] s,
		input logic [10:0] l, input logic [3:0] sl, input logic [2:0] st);
		mk = '{h, t, s, l, sl, st, 1'b0};
	endfunction

	always_comb begin
		cmd_take = 1'b0;
		ob_load = 1'b0;
		ob_next = pend_q;
		we_sl = 1'b0; wa_sl = '0; wd_seq = nseq_q; wd_len = sat_len;
		we_tk = 1'b0; wa_tk = ptr_q; wd_tk = tick_q;
		if (ph_q == P_IDLE && cmd_valid && !pend_v_q && ob_free) begin
			cmd_take = 1'b1;
			if (cmd_word.kind == KIND_SEND && cs_q == CS_CONNECTED
				&& fill_q < (SlotW+1)'(RingSlots)) begin
				we_sl = 1'b1;
				wa_sl = head_q + fill_q[SlotW-1:0];
				we_tk = 1'b1;
				wa_tk = wa_sl;
			end
		end
		if (ph_q == P_RESEND && resend_go) begin
			we_tk = 1'b1;
			ob_load = pend_v_q;
		end
		if (ph_q == P_FILL && rd_ok_q && ob_free && can_fill) begin
			we_tk = 1'b1;
			ob_load = pend_v_q;
		end
		if (ph_q == P_EMIT && pend_v_q && ob_free) begin
			ob_load = 1'b1;
			ob_next.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= P_IDLE;
			cs_q <= CS_CLOSED;
			nseq_q <= '0; tick_q <= '0; ack_q <= '0;
			rcnt_q <= '0; rtim_q <= '0;
			head_q <= '0; unsent_q <= '0; ptr_q <= '0;
			fill_q <= '0; unack_q <= '0;
			nres_q <= '0; k_q <= '0; send_q <= 1'b0; rd_ok_q <= 1'b0;
			pend_v_q <= 1'b0; ob_v_q <= 1'b0;
			pend_q <= '0; ob_q <= '0;
		end else begin
			if (ob_load) begin
				ob_q <= ob_next;
				ob_v_q <= 1'b1;
			end else if (!out_stall) ob_v_q <= 1'b0;
			unique case (ph_q)
				P_IDLE: begin
					if (cmd_take) begin
						nres_q <= (cmd_word.kind == KIND_TICK && retry_due) ? 4'd1 : 4'd0;
						send_q <= we_sl;
						unique case (cmd_word.kind)
							KIND_OPEN: begin
								if (cs_q == CS_CLOSED) begin
									cs_q <= CS_SYNSENT; nseq_q <= 32'd1;
									rcnt_q <= '0; rtim_q <= '0;
									pend_q <= mk(1'b1, TX_SYN, '0, '0, '0, ST_NONE);
								end else pend_q <= mk(1'b0, TX_SYN, '0, '0, '0, ST_REJECTED);
								pend_v_q <= 1'b1; ph_q <= P_EMIT;
							end
							KIND_SEND: begin
								if (we_sl) begin
									nseq_q <= nseq_q + 32'(sat_len);
									fill_q <= fill_q + 1'b1;
									ptr_q <= unsent_q; rd_ok_q <= 1'b0;
									ph_q <= P_FILL;
								end else begin
									pend_q <= mk(1'b0, TX_SYN, '0, '0, '0, ST_REJECTED);
									pend_v_q <= 1'b1; ph_q <= P_EMIT;
								end
							end
							KIND_RECV: begin
								if (ports_ok && cs_q == CS_SYNSENT
									&& cmd_word.rx_type == RX_SYNACK) begin
									cs_q <= CS_CONNECTED;
									pend_q <= mk(1'b0, TX_SYN, '0, '0, '0, ST_CONNECTED);
									pend_v_q <= 1'b1; ph_q <= P_EMIT;
								end else if (ports_ok && cs_q == CS_CONNECTED
									&& cmd_word.rx_type == RX_DATAACK) begin
									ack_q <= cmd_word.rx_ack_num;
									ptr_q <= head_q; rd_ok_q <= 1'b0;
									ph_q <= P_POP;
								end else if (ports_ok && cs_q == CS_FINWAIT
									&& cmd_word.rx_type == RX_FINACK) begin
									cs_q <= CS_CLOSED;
									head_q <= '0; unsent_q <= '0; fill_q <= '0; unack_q <= '0;
									pend_q <= mk(1'b0, TX_SYN, '0, '0, '0, ST_CLOSED);
									pend_v_q <= 1'b1; ph_q <= P_EMIT;
								end
							end
							KIND_CLOSE: begin
								if (cs_q == CS_SYNSENT || cs_q == CS_CONNECTED) begin
									cs_q <= CS_FINWAIT; rcnt_q <= '0; rtim_q <= '0;
									pend_q <= mk(1'b1, TX_FIN, '0, '0, '0, ST_NONE);
								end else pend_q <= mk(1'b0, TX_SYN, '0, '0, '0, ST_REJECTED);
								pend_v_q <= 1'b1; ph_q <= P_EMIT;
							end
							KIND_TICK: begin
								tick_q <= tick_q + 32'd1;
								ptr_q <= head_q; rd_ok_q <= 1'b0;
								ph_q <= P_AGE;
								if (cs_q == CS_SYNSENT || cs_q == CS_FINWAIT) begin
									rtim_q <= retry_due ? 16'd0 : ntim;
									if (retry_due) begin
										pend_v_q <= 1'b1;
										if (rcnt_q < tries) begin
											rcnt_q <= rcnt_q + 8'd1;
											pend_q <= mk(1'b1, syn ? TX_SYN : TX_FIN, '0, '0,
												'0, ST_NONE);
										end else begin
											cs_q <= CS_CLOSED; rcnt_q <= '0;
											head_q <= '0; unsent_q <= '0;
											fill_q <= '0; unack_q <= '0;
											pend_q <= mk(1'b0, TX_SYN, '0, '0, '0,
												syn ? ST_CONN_FAIL : ST_CLOSE_FAIL);
										end
									end
								end
							end
							default: ;
						endcase
					end
				end
				P_FILL: begin
					// The RAM read of ptr_q is registered, so rd_ok_q waits for its data before it can go out.
					if (!rd_ok_q) rd_ok_q <= 1'b1;
					else if (ob_free) begin
						if (can_fill) begin
							pend_q <= mk(1'b1, TX_DATA, seq_rd, len_rd, ptr_q, ST_NONE);
							pend_v_q <= 1'b1;
							nres_q <= nres_q + 4'd1;
							unack_q <= unack_q + 1'b1;
							unsent_q <= ptr_q + 1'b1;
							ptr_q <= ptr_q + 1'b1;
							rd_ok_q <= 1'b0;
						end else begin
							if (send_q) begin
								if (pend_v_q) pend_q.status <= ST_ACCEPTED;
								else pend_q <= mk(1'b0, TX_SYN, '0, '0, '0, ST_ACCEPTED);
								pend_v_q <= 1'b1;
							end
							ph_q <= P_EMIT;
						end
					end
				end
				P_POP: begin
					if (!rd_ok_q) rd_ok_q <= 1'b1;
					else if (unack_q != '0 && seq_rd < ack_q) begin
						head_q <= ptr_q + 1'b1;
						ptr_q <= ptr_q + 1'b1;
						fill_q <= fill_q - 1'b1;
						unack_q <= unack_q - 1'b1;
						rd_ok_q <= 1'b0;
					end else begin
						ptr_q <= unsent_q; rd_ok_q <= 1'b0;
						ph_q <= P_FILL;
					end
				end
				P_AGE: begin
					if (!rd_ok_q) rd_ok_q <= 1'b1;
					else if (unack_q != '0 && (tick_q - tk_rd) > 32'(cfg.resend_age)) begin
						k_q <= '0; rd_ok_q <= 1'b1;
						ph_q <= P_RESEND;
					end else ph_q <= P_EMIT;
				end
				P_RESEND: begin
					if (k_q == unack_q || nres_q == 4'd8) ph_q <= P_EMIT;
					else if (!rd_ok_q) rd_ok_q <= 1'b1;
					else if (ob_free) begin
						pend_q <= mk(1'b1, TX_DATA, seq_rd, len_rd, ptr_q, ST_NONE);
						pend_v_q <= 1'b1;
						nres_q <= nres_q + 4'd1;
						k_q <= k_q + 1'b1;
						ptr_q <= ptr_q + 1'b1;
						rd_ok_q <= 1'b0;
					end
				end
				P_EMIT: begin
					if (!pend_v_q) ph_q <= P_IDLE;
					else if (ob_free) begin
						pend_v_q <= 1'b0;
						ph_q <= P_IDLE;
					end
				end
				default: ph_q <= P_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) unack_q <= fill_q)
		else $error("more unacknowledged entries than queued");
	assert property (@(posedge clk) disable iff (!arst_n) unack_q <= (SlotW+1)'(Window))
		else $error("window exceeded");
	assert property (@(posedge clk) disable iff (!arst_n) cmd_take |-> !pend_v_q)
		else $error("new word taken with a result still held");
endmodule
`default_nettype wire

// ----- src/go_back_n_transport_sender.sv -----
// Top level of the Go-Back-N transport sender.
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall | in_word_t
//  out     | output    | out_valid/out_stall | out_word_t
//  cfg     | input     | APB psel/penable  | 32-bit registers at 4*i
// The engine takes no new word until it is back in idle; each ring entry popped or sent
// needs a ring read, and every ring read waits for the registered RAM output.
// A word is registered in the input queue before the engine can take it.
// Reset clears connection state and pointers; the ring RAMs are not cleared.
// A two-word input queue lets the front accept while the engine waits on out_stall.
`default_nettype none
module go_back_n_transport_sender import gbn_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire in_word_t in_word,
	output logic out_valid,
	input wire logic out_stall,
	output out_word_t out_word,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	cfg_t cfg;
	logic cmd_valid, cmd_take;
	in_word_t cmd_word;

	gbn_cfg u_cfg (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
		.pready, .cfg);
	gbn_front u_front (.clk, .arst_n, .in_valid, .in_stall, .in_word, .cmd_valid,
		.cmd_take, .cmd_word);
	gbn_engine u_engine (.clk, .arst_n, .cfg, .cmd_valid, .cmd_take, .cmd_word,
		.out_valid, .out_stall, .out_word);
endmodule
`default_nettype wire
